// ===== design/ccc_pkg.sv =====
// Shared types, constants and calendar helper functions for the calendar clock counter.
package ccc_pkg;

    localparam int unsigned BASE_YEAR = 2000;
    localparam int unsigned END_YEAR  = 2100;
    localparam int unsigned YEAR_SPAN = END_YEAR - BASE_YEAR;

    localparam int unsigned YEAR_OFF_W = 7;

    typedef enum logic [1:0] {
        KIND_TICK       = 2'd0,
        KIND_LOAD_CALC  = 2'd1,
        KIND_LOAD_GIVEN = 2'd2
    } kind_t;

    // One input word as held in the input register.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] load_year;
        logic [7:0]  load_month;
        logic [7:0]  load_day;
        logic [7:0]  load_weekday;
        logic [7:0]  load_hour;
        logic [7:0]  load_minute;
        logic [7:0]  load_second;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_time_t;

    // Length of a month (1..12); leap selects 29 days for February.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        unique case (month)
            4'd2:    return leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   return 5'd30;
            default: return 5'd31;
        endcase
    endfunction

    // Month offsets of the weekday rule.
    function automatic logic [2:0] month_key(input logic [3:0] month);
        unique case (month)
            4'd1:    return 3'd0;
            4'd2:    return 3'd3;
            4'd3:    return 3'd2;
            4'd4:    return 3'd5;
            4'd5:    return 3'd0;
            4'd6:    return 3'd3;
            4'd7:    return 3'd5;
            4'd8:    return 3'd1;
            4'd9:    return 3'd4;
            4'd10:   return 3'd6;
            4'd11:   return 3'd2;
            4'd12:   return 3'd4;
            default: return 3'd0;
        endcase
    endfunction

    // Remainder by 7: octal digits fold because 8 is 1 mod 7.
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7)
        begin
            return 3'(s2 - 4'd7);
        end
        return s2[2:0];
    endfunction

endpackage

// ===== design/ccc_item_if.sv =====
// Input channel of the calendar clock counter: valid/ready plus one item word.
interface ccc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] load_year;
    logic [7:0]  load_month;
    logic [7:0]  load_day;
    logic [7:0]  load_weekday;
    logic [7:0]  load_hour;
    logic [7:0]  load_minute;
    logic [7:0]  load_second;

    modport source (
        output valid, kind, load_year, load_month, load_day, load_weekday,
               load_hour, load_minute, load_second,
        input  ready
    );

    modport sink (
        input  valid, kind, load_year, load_month, load_day, load_weekday,
               load_hour, load_minute, load_second,
        output ready
    );
endinterface

// ===== design/ccc_time_if.sv =====
// Result channel of the calendar clock counter: valid/ready plus one time word.
interface ccc_time_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (
        output valid, year, month, day, weekday, hour, minute, second,
        input  ready
    );

    modport sink (
        input  valid, year, month, day, weekday, hour, minute, second,
        output ready
    );
endinterface

// ===== design/ccc_in_stage.sv =====
// Input register: captures one item word and holds it until the calendar takes it.
module ccc_in_stage
    import ccc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    ccc_item_if.sink        item,
    input  logic            take,
    output logic            valid,
    output item_t           data
);

    logic  valid_reg;
    logic  valid_next;
    item_t data_reg;
    logic  accept;

    assign item.ready = !valid_reg || take;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= '{
                kind:         item.kind,
                load_year:    item.load_year,
                load_month:   item.load_month,
                load_day:     item.load_day,
                load_weekday: item.load_weekday,
                load_hour:    item.load_hour,
                load_minute:  item.load_minute,
                load_second:  item.load_second
            };
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== design/ccc_calendar.sv =====
// Calendar state registers with the tick carry chain and the load clean-up logic.
module ccc_calendar
    import ccc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  item_t     cmd,
    output cal_time_t upd
);

    logic [5:0]            sec_reg,  sec_next;
    logic [5:0]            min_reg,  min_next;
    logic [4:0]            hour_reg, hour_next;
    logic [4:0]            day_reg,  day_next;
    logic [3:0]            month_reg, month_next;
    logic [YEAR_OFF_W-1:0] year_reg, year_next;
    logic [2:0]            wday_reg, wday_next;

    // tick path
    logic                  sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
    logic [5:0]            t_sec, t_min;
    logic [4:0]            t_hour, t_day;
    logic [3:0]            t_month;
    logic [YEAR_OFF_W-1:0] t_year;
    logic [2:0]            t_wday;

    // load path
    logic                  year_ok, month_ok, day_ok, early;
    logic [YEAR_OFF_W-1:0] l_year, shift_year;
    logic [3:0]            l_month;
    logic [4:0]            l_dim, l_day;
    logic [6:0]            key_base;
    logic [7:0]            key_sum;
    logic [2:0]            w_calc, w_given;
    logic [4:0]            l_hour;
    logic [5:0]            l_min, l_sec;

    // Tick: ripple the carry from seconds up to the year.
    always_comb
    begin
        sec_wrap   = (sec_reg == 6'd59);
        min_wrap   = (min_reg == 6'd59);
        hour_wrap  = (hour_reg == 5'd23);
        day_wrap   = (day_reg >= days_in(month_reg, year_reg[1:0] == 2'b00));
        month_wrap = (month_reg == 4'd12);

        t_sec   = sec_wrap ? 6'd0 : sec_reg + 6'd1;
        t_min   = min_reg;
        t_hour  = hour_reg;
        t_day   = day_reg;
        t_month = month_reg;
        t_year  = year_reg;
        t_wday  = wday_reg;
        if (sec_wrap)
        begin
            t_min = min_wrap ? 6'd0 : min_reg + 6'd1;
            if (min_wrap)
            begin
                t_hour = hour_wrap ? 5'd0 : hour_reg + 5'd1;
                if (hour_wrap)
                begin
                    t_wday = (wday_reg >= 3'd7) ? 3'd1 : wday_reg + 3'd1;
                    t_day  = day_wrap ? 5'd1 : day_reg + 5'd1;
                    if (day_wrap)
                    begin
                        t_month = month_wrap ? 4'd1 : month_reg + 4'd1;
                        if (month_wrap)
                        begin
                            // wrap 2099 back to 2000
                            t_year = (year_reg == YEAR_OFF_W'(YEAR_SPAN - 1))
                                   ? '0 : year_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Load: clean each field, then derive the weekday from the cleaned date.
    always_comb
    begin
        year_ok  = (cmd.load_year >= 16'(BASE_YEAR)) && (cmd.load_year < 16'(END_YEAR));
        l_year   = year_ok ? YEAR_OFF_W'(cmd.load_year - 16'(BASE_YEAR)) : '0;
        month_ok = (cmd.load_month >= 8'd1) && (cmd.load_month <= 8'd12);
        l_month  = month_ok ? cmd.load_month[3:0] : 4'd1;
        l_dim    = days_in(l_month, l_year[1:0] == 2'b00);
        day_ok   = (cmd.load_day != 8'd0) && (cmd.load_day <= {3'b000, l_dim});
        l_day    = day_ok ? cmd.load_day[4:0] : 5'd1;

        // Year term mod 7 reduces to k + floor(k/4), k = offset less one in Jan/Feb.
        early      = (l_month < 4'd3);
        shift_year = l_year - YEAR_OFF_W'(early);
        if (early && (l_year == '0))
        begin
            key_base = 7'd5;   // 1999 folds to -2, i.e. 5 mod 7
        end
        else
        begin
            key_base = shift_year + (shift_year >> 2);
        end
        key_sum = 8'(key_base) + 8'(month_key(l_month)) + 8'(l_day);
        w_calc  = mod7(key_sum) + 3'd1;

        w_given = ((cmd.load_weekday >= 8'd1) && (cmd.load_weekday <= 8'd7))
                ? cmd.load_weekday[2:0] : 3'd1;

        l_hour = (cmd.load_hour   > 8'd23) ? 5'd0 : cmd.load_hour[4:0];
        l_min  = (cmd.load_minute > 8'd59) ? 6'd0 : cmd.load_minute[5:0];
        l_sec  = (cmd.load_second > 8'd59) ? 6'd0 : cmd.load_second[5:0];
    end

    always_comb
    begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        wday_next  = wday_reg;
        unique case (kind_t'(cmd.kind))
            KIND_TICK:
            begin
                sec_next   = t_sec;
                min_next   = t_min;
                hour_next  = t_hour;
                day_next   = t_day;
                month_next = t_month;
                year_next  = t_year;
                wday_next  = t_wday;
            end
            KIND_LOAD_CALC,
            KIND_LOAD_GIVEN:
            begin
                sec_next   = l_sec;
                min_next   = l_min;
                hour_next  = l_hour;
                day_next   = l_day;
                month_next = l_month;
                year_next  = l_year;
                wday_next  = (kind_t'(cmd.kind) == KIND_LOAD_GIVEN) ? w_given : w_calc;
            end
            default:
            begin
                // unused kind: hold the time
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg   <= 6'd0;
            min_reg   <= 6'd0;
            hour_reg  <= 5'd0;
            day_reg   <= 5'd1;
            month_reg <= 4'd1;
            year_reg  <= '0;
            wday_reg  <= 3'd7;
        end
        else if (step)
        begin
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            wday_reg  <= wday_next;
        end
    end

    assign upd = '{
        year:    12'(BASE_YEAR) + 12'(year_next),
        month:   month_next,
        day:     day_next,
        weekday: wday_next,
        hour:    hour_next,
        minute:  min_next,
        second:  sec_next
    };

endmodule

// ===== design/ccc_out_stage.sv =====
// Result register: holds one time word until the receiver takes it.
module ccc_out_stage
    import ccc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  cal_time_t   data,
    output logic        free,
    ccc_time_if.source  result
);

    logic      valid_reg;
    logic      valid_next;
    cal_time_t data_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result.valid   = valid_reg;
    assign result.year    = data_reg.year;
    assign result.month   = data_reg.month;
    assign result.day     = data_reg.day;
    assign result.weekday = data_reg.weekday;
    assign result.hour    = data_reg.hour;
    assign result.minute  = data_reg.minute;
    assign result.second  = data_reg.second;

endmodule

// ===== design/calendar_clock_counter.sv =====
// Top level of the calendar clock counter (years 2000 to 2099).
//
// Channels: "item" takes one word per handshake (valid and ready high at a
// rising edge). Kind tick advances the time by one second with carries up to
// the year; kind load with computed weekday sets date and time and derives the
// weekday from the date; kind load with given weekday takes it from the word.
// Out-of-range load fields are cleaned (year to 2000, month/day/weekday to 1,
// hour/minute/second to 0). Kind 3 leaves the time alone.
// "result" returns one word per item: the time as it stands after that item.
//
// Flow: the input register captures the word at the accepting edge; the
// calendar update lands in the result register once that register is free
// (empty or being taken), and the result is valid from then on.
// Throughput: one item per cycle while the receiver keeps result.ready high;
// the input and result registers let a new word enter while a finished
// result still waits.
//
// Reset (rst_n low, asynchronous): both stages empty, time set to
// Saturday 1 Jan 2000 00:00:00.
// Receiver stall: the result register holds its word, the calendar stops,
// the input register fills and then item.ready drops. Nothing is lost.
module calendar_clock_counter
    import ccc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ccc_item_if.sink    item,
    ccc_time_if.source  result
);

    logic      held_valid;
    item_t     held_item;
    logic      out_free;
    logic      step;
    cal_time_t upd_time;

    // Advance the held word whenever the result register can take its answer.
    assign step = held_valid && out_free;

    ccc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (step),
        .valid (held_valid),
        .data  (held_item)
    );

    ccc_calendar u_calendar (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (held_item),
        .upd   (upd_time)
    );

    ccc_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step),
        .data   (upd_time),
        .free   (out_free),
        .result (result)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the calendar clock counter: directed and random items with scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccc_pkg::*;

    // Kind 3 carries no name in the package; the block must leave the time alone.
    localparam logic [1:0] KIND_HOLD = 2'd3;

    // Month offsets of the day-of-week rule, January first.
    localparam int unsigned MONTH_KEY [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    // Stop sending once this many words have gone in; drop all idling for the tail.
    localparam int unsigned TOTAL_WORDS = 1725;
    localparam int unsigned QUIET_FROM  = TOTAL_WORDS - 200;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ccc_item_if item_ch ();
    ccc_time_if time_ch ();

    calendar_clock_counter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (time_ch)
    );

    always #10 clk = ~clk;

    // Days in a month, given the year as an offset from 2000. Every fourth year
    // is a leap year, which holds across 2000..2099.
    function automatic int unsigned month_length(input int unsigned mo, input int unsigned off);
        if (mo == 2)
        begin
            return (off % 4 == 0) ? 29 : 28;
        end
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
        begin
            return 30;
        end
        return 31;
    endfunction

    // Scoreboard: tracks the calendar as the block should see it, and queues the
    // time word that each accepted input should produce.
    class calendar_scoreboard;
        cal_time_t   pending_times [$];
        int unsigned fail_count;
        int unsigned sec_now;
        int unsigned min_now;
        int unsigned hour_now;
        int unsigned day_now;
        int unsigned month_now;
        int unsigned year_off;
        int unsigned wday_now;

        function new();
            fail_count = 0;
            sec_now    = 0;
            min_now    = 0;
            hour_now   = 0;
            day_now    = 1;
            month_now  = 1;
            year_off   = 0;
            wday_now   = 7;
        endfunction

        // Advance the calendar for one accepted input word and queue the time.
        function void note_item(input item_t w);
            int unsigned yr;
            int unsigned mo;
            int unsigned dy;
            int unsigned wd;
            int unsigned shifted;
            int unsigned acc;
            cal_time_t   want;
            if (w.kind == KIND_TICK)
            begin
                // Carry chain: second, minute, hour, then weekday and date at midnight.
                sec_now++;
                if (sec_now == 60)
                begin
                    sec_now = 0;
                    min_now++;
                    if (min_now == 60)
                    begin
                        min_now = 0;
                        hour_now++;
                        if (hour_now == 24)
                        begin
                            hour_now = 0;
                            wday_now = (wday_now >= 7) ? 1 : wday_now + 1;
                            day_now++;
                            if (day_now > month_length(month_now, year_off))
                            begin
                                day_now = 1;
                                month_now++;
                                if (month_now > 12)
                                begin
                                    month_now = 1;
                                    year_off  = (year_off + 1 >= YEAR_SPAN) ? 0 : year_off + 1;
                                end
                            end
                        end
                    end
                end
            end
            else if (w.kind == KIND_LOAD_CALC || w.kind == KIND_LOAD_GIVEN)
            begin
                // Clean each field in order; the day depends on the cleaned month and year.
                yr = w.load_year;
                if (yr < BASE_YEAR || yr >= END_YEAR)
                begin
                    yr = BASE_YEAR;
                end
                year_off = yr - BASE_YEAR;
                mo = w.load_month;
                if (mo < 1 || mo > 12)
                begin
                    mo = 1;
                end
                month_now = mo;
                dy = w.load_day;
                if (dy < 1 || dy > month_length(mo, year_off))
                begin
                    dy = 1;
                end
                day_now = dy;
                if (w.kind == KIND_LOAD_GIVEN)
                begin
                    wd = w.load_weekday;
                    if (wd < 1 || wd > 7)
                    begin
                        wd = 1;
                    end
                end
                else
                begin
                    // Day-of-week rule: January and February count in the prior year.
                    shifted = yr - ((mo < 3) ? 1 : 0);
                    acc = shifted + shifted / 4 - shifted / 100 + shifted / 400
                        + MONTH_KEY[mo - 1] + dy;
                    wd = 1 + acc % 7;
                end
                wday_now = wd;
                hour_now = (w.load_hour > 23) ? 0 : w.load_hour;
                min_now  = (w.load_minute > 59) ? 0 : w.load_minute;
                sec_now  = (w.load_second > 59) ? 0 : w.load_second;
            end
            want.year    = 12'(BASE_YEAR + year_off);
            want.month   = 4'(month_now);
            want.day     = 5'(day_now);
            want.weekday = 3'(wday_now);
            want.hour    = 5'(hour_now);
            want.minute  = 6'(min_now);
            want.second  = 6'(sec_now);
            pending_times.push_back(want);
        endfunction

        function void check_field(input string name, input logic [11:0] want,
                                  input logic [11:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        // Compare one accepted time word with the oldest queued time.
        function void check_time(input cal_time_t got);
            cal_time_t want;
            if (pending_times.size() == 0)
            begin
                $error("time word with no expected time: %p", got);
                fail_count++;
                return;
            end
            want = pending_times.pop_front();
            check_field("year",    want.year,          got.year);
            check_field("month",   12'(want.month),    12'(got.month));
            check_field("day",     12'(want.day),      12'(got.day));
            check_field("weekday", 12'(want.weekday),  12'(got.weekday));
            check_field("hour",    12'(want.hour),     12'(got.hour));
            check_field("minute",  12'(want.minute),   12'(got.minute));
            check_field("second",  12'(want.second),   12'(got.second));
        endfunction
    endclass

    calendar_scoreboard sb = new();

    // Set once the tail of the run starts: no new gaps or stall bursts begin from then on.
    bit          quiet      = 1'b0;
    int unsigned words_sent = 0;

    function automatic item_t make_word(input logic [1:0] k, input int unsigned y,
                                        input int unsigned mo, input int unsigned d,
                                        input int unsigned wd, input int unsigned h,
                                        input int unsigned mi, input int unsigned s);
        item_t w;
        w.kind         = k;
        w.load_year    = 16'(y);
        w.load_month   = 8'(mo);
        w.load_day     = 8'(d);
        w.load_weekday = 8'(wd);
        w.load_hour    = 8'(h);
        w.load_minute  = 8'(mi);
        w.load_second  = 8'(s);
        return w;
    endfunction

    // A tick carries a random payload; the block must ignore it.
    function automatic item_t tick_word();
        return make_word(KIND_TICK, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
    endfunction

    // Drive one input word: optional idle burst, then hold valid until accepted.
    // Everything changes at the falling edge; acceptance is seen at the rising edge.
    task automatic send_word(input item_t w);
        int unsigned gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 10);
        end
        repeat (gap)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= w.kind;
        item_ch.load_year    <= w.load_year;
        item_ch.load_month   <= w.load_month;
        item_ch.load_day     <= w.load_day;
        item_ch.load_weekday <= w.load_weekday;
        item_ch.load_hour    <= w.load_hour;
        item_ch.load_minute  <= w.load_minute;
        item_ch.load_second  <= w.load_second;
        do
        begin
            @(posedge clk);
        end
        while (item_ch.ready !== 1'b1);
        sb.note_item(w);
        words_sent++;
    endtask

    // Result side: random stall bursts, none starting once the run goes quiet.
    initial
    begin
        int unsigned stall_left;
        stall_left    = 0;
        time_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                time_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left    = $urandom_range(1, 10) - 1;
                time_ch.ready <= 1'b0;
            end
            else
            begin
                time_ch.ready <= 1'b1;
            end
        end
    end

    // Check every accepted time word against the scoreboard.
    always @(posedge clk)
    begin
        if (time_ch.valid === 1'b1 && time_ch.ready === 1'b1)
        begin
            sb.check_time({time_ch.year, time_ch.month, time_ch.day, time_ch.weekday,
                           time_ch.hour, time_ch.minute, time_ch.second});
        end
    end

    // Main stimulus.
    initial
    begin
        int unsigned pick;
        int unsigned run;
        int unsigned yr;
        int unsigned mo;
        int unsigned len;
        int unsigned dy;
        logic [1:0]  load_kind;

        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_TICK;
        item_ch.load_year    = '0;
        item_ch.load_month   = '0;
        item_ch.load_day     = '0;
        item_ch.load_weekday = '0;
        item_ch.load_hour    = '0;
        item_ch.load_minute  = '0;
        item_ch.load_second  = '0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Hold word first: it must report the reset time untouched.
        send_word(make_word(KIND_HOLD, 0, 0, 0, 0, 0, 0, 0));
        send_word(tick_word());
        // All-zero and all-ones loads: every date and time field falls back to its default.
        send_word(make_word(KIND_LOAD_CALC, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(KIND_LOAD_GIVEN, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // Just outside each range, then out-of-range year, day and weekday with the other fields at their top.
        send_word(make_word(KIND_LOAD_GIVEN, 1999, 13, 0, 8, 24, 60, 60));
        send_word(make_word(KIND_LOAD_GIVEN, 2100, 12, 32, 0, 23, 59, 59));
        // Last second of 2099 wraps to 2000; the computed load ignores its weekday.
        send_word(make_word(KIND_LOAD_CALC, 2099, 12, 31, 200, 23, 59, 59));
        send_word(tick_word());
        // Leap day end, with the weekday wrapping Saturday to Sunday.
        send_word(make_word(KIND_LOAD_GIVEN, 2024, 2, 29, 7, 23, 59, 59));
        send_word(tick_word());
        // No leap day in a common year.
        send_word(make_word(KIND_LOAD_CALC, 2023, 2, 29, 0, 10, 20, 30));
        send_word(make_word(KIND_LOAD_CALC, 2023, 2, 28, 0, 23, 59, 59));
        send_word(tick_word());
        send_word(make_word(KIND_LOAD_CALC, 2024, 2, 28, 0, 23, 59, 59));
        send_word(tick_word());
        // Thirty-day month: day 31 is rejected, day 30 rolls to the next month.
        send_word(make_word(KIND_LOAD_CALC, 2000, 4, 31, 0, 0, 0, 0));
        send_word(make_word(KIND_LOAD_GIVEN, 2050, 6, 30, 3, 23, 59, 59));
        send_word(tick_word());
        // Computed weekday on both sides of the March boundary.
        send_word(make_word(KIND_LOAD_CALC, 2001, 1, 1, 0, 0, 0, 0));
        send_word(make_word(KIND_LOAD_CALC, 2099, 3, 1, 0, 0, 0, 0));
        // A minute and hour carry without a date change, then a plain second step.
        send_word(make_word(KIND_LOAD_GIVEN, 2000, 1, 1, 7, 0, 59, 59));
        send_word(tick_word());
        send_word(make_word(KIND_LOAD_CALC, 2000, 5, 15, 0, 12, 0, 58));
        send_word(tick_word());
        send_word(make_word(KIND_HOLD, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom));

        // Random part. Mostly a clean load close to a rollover followed by ticks,
        // so the carries reach day, month and year; the rest is noise, broken loads and tick runs.
        while (words_sent < TOTAL_WORDS)
        begin
            if (words_sent >= QUIET_FROM)
            begin
                quiet = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick <= 6)
            begin
                yr  = ($urandom_range(0, 7) == 0) ? 2099 : $urandom_range(2000, 2099);
                mo  = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
                len = month_length(mo, yr - BASE_YEAR);
                dy  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, len)
                                                  : len - $urandom_range(0, 1);
                load_kind = $urandom_range(0, 1) ? KIND_LOAD_GIVEN : KIND_LOAD_CALC;
                send_word(make_word(load_kind, yr, mo, dy, $urandom_range(1, 7),
                                    $urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
                                    $urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
                                    $urandom_range(0, 1) ? $urandom_range(55, 59)
                                                         : $urandom_range(0, 59)));
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 70)
                                                  : $urandom_range(1, 6);
                repeat (run) send_word(tick_word());
            end
            else if (pick == 7)
            begin
                // Noise: any kind, any payload bits.
                send_word(make_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom));
            end
            else if (pick == 8)
            begin
                // Broken load: fields mostly out of range, then a few ticks.
                load_kind = $urandom_range(0, 1) ? KIND_LOAD_GIVEN : KIND_LOAD_CALC;
                send_word(make_word(load_kind, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom));
                repeat ($urandom_range(1, 4)) send_word(tick_word());
            end
            else
            begin
                repeat ($urandom_range(1, 20)) send_word(tick_word());
            end
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;

        // Drain: wait for every queued time, then keep watching for stray words before the verdict.
        while (sb.pending_times.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (sb.fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
